### hw/rtl/srmw_pkg.sv
// Shared types, constants and helpers for the sector read-modify-write splitter.
// Used by srmw_front, srmw_queue, srmw_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srmw_pkg;

   // Drive geometry and scratch buffer size
   localparam int SECTOR_BYTES   = 512;
   localparam int BOUNCE_SECTORS = 8;
   localparam int SECTOR_SHIFT   = $clog2(SECTOR_BYTES);

   // Field widths
   localparam int POS_W  = 57;
   localparam int SIZE_W = 32;
   localparam int LBA_W  = 48;
   localparam int CNT_W  = 4;
   localparam int SOFF_W = 12;

   // Chunk arithmetic widths
   localparam int SEC_W   = $clog2(BOUNCE_SECTORS + 1);
   localparam int SPAN_W  = SIZE_W + 1;
   localparam int SECR_W  = SPAN_W - SECTOR_SHIFT + 1;
   localparam int WHOLE_W = SEC_W + SECTOR_SHIFT;

   // Result queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // Input item kinds
   localparam logic KIND_REQUEST    = 1'b0;
   localparam logic KIND_COMPLETION = 1'b1;

   typedef enum logic [2:0] {
      RK_READ       = 3'd0,
      RK_WRITE      = 3'd1,
      RK_TO_SCRATCH = 3'd2,
      RK_TO_BUFFER  = 3'd3,
      RK_DONE       = 3'd4,
      RK_FAIL       = 3'd5
   } srmw_kind_type;

   // Outstanding drive command
   typedef enum logic [1:0] {
      AW_NONE       = 2'd0,
      AW_DATA_READ  = 2'd1,
      AW_MERGE_READ = 2'd2,
      AW_WRITE      = 2'd3
   } srmw_await_type;

   typedef struct packed {
      srmw_kind_type     kind;
      logic [LBA_W-1:0]  lba;
      logic [CNT_W-1:0]  num_sectors;
      logic [SOFF_W-1:0] scratch_offset;
      logic [SIZE_W-1:0] buffer_offset;
      logic [SIZE_W-1:0] byte_length;
      logic              last;
   } srmw_rsp_type;

   // Up to two results pushed per cycle, rec0 first
   typedef struct packed {
      logic [1:0]   num;
      srmw_rsp_type rec0;
      srmw_rsp_type rec1;
   } srmw_push_type;

   function automatic srmw_rsp_type make_rsp(
      input srmw_kind_type     kind,
      input logic [LBA_W-1:0]  lba,
      input logic [CNT_W-1:0]  cnt,
      input logic [SOFF_W-1:0] soff,
      input logic [SIZE_W-1:0] boff,
      input logic [SIZE_W-1:0] len,
      input logic              last
   );
      srmw_rsp_type r;
      r.kind           = kind;
      r.lba            = lba;
      r.num_sectors    = cnt;
      r.scratch_offset = soff;
      r.buffer_offset  = boff;
      r.byte_length    = len;
      r.last           = last;
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/srmw_front.sv
// Front part: accepts items, keeps the transfer state and works out each chunk.
// Depends on srmw_pkg; pushes up to two results a cycle into srmw_queue.
`timescale 1ns / 1ps
`default_nettype none

module srmw_front import srmw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [POS_W-1:0]  req_start_offset,
   input  logic [SIZE_W-1:0] req_request_bytes,
   input  logic              req_write_request,
   input  logic              req_command_failed,
   input  logic              q_room,
   output srmw_push_type     push
);

   typedef enum logic [3:0] {
      ST_READY = 4'b0001,
      ST_SPAN  = 4'b0010,
      ST_CHUNK = 4'b0100,
      ST_ISSUE = 4'b1000
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic              active_ff, active_in;
   logic              writing_ff, writing_in;
   srmw_await_type    awaiting_ff, awaiting_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] done_ff, done_in;
   logic [SEC_W-1:0]  sectors_ff, sectors_in;
   logic [SIZE_W-1:0] xfer_ff, xfer_in;
   logic              partial_ff, partial_in;

   logic [SECTOR_SHIFT-1:0] soff;
   logic [SOFF_W-1:0]       soff_out;
   logic [LBA_W-1:0]        lba;
   logic [CNT_W-1:0]        cnt_out;
   logic [SPAN_W-1:0]       span;
   logic [SECR_W-1:0]       sec_raw;
   logic [SEC_W-1:0]        sec_cap;
   logic [WHOLE_W-1:0]      whole;
   logic [WHOLE_W-1:0]      room;
   logic [SIZE_W-1:0]       room_ext;
   logic [SIZE_W-1:0]       xfer_calc;
   logic                    partial_calc;
   logic [SIZE_W-1:0]       done_sum;
   logic                    last_chunk;
   logic                    accept;

   // Current drive position split into sector and offset
   assign soff     = pos_ff[SECTOR_SHIFT-1:0];
   assign soff_out = SOFF_W'(soff);
   assign lba      = LBA_W'(pos_ff[POS_W-1:SECTOR_SHIFT]);
   assign cnt_out  = CNT_W'(sectors_ff);

   // First chunk step: sectors covered, capped at the scratch size
   assign span    = {1'b0, rem_ff} + SPAN_W'(soff);
   assign sec_raw = SECR_W'(span[SPAN_W-1:SECTOR_SHIFT])
                  + SECR_W'(span[SECTOR_SHIFT-1:0] != '0);
   assign sec_cap = (sec_raw > SECR_W'(BOUNCE_SECTORS)) ? SEC_W'(BOUNCE_SECTORS)
                                                        : SEC_W'(sec_raw);

   // Second chunk step: bytes moved and whether the chunk is partial
   assign whole        = WHOLE_W'(sectors_ff) << SECTOR_SHIFT;
   assign room         = whole - WHOLE_W'(soff);
   assign room_ext     = SIZE_W'(room);
   assign xfer_calc    = (rem_ff < room_ext) ? rem_ff : room_ext;
   assign partial_calc = (soff != '0) || (xfer_calc != SIZE_W'(whole));

   assign done_sum   = done_ff + xfer_ff;
   assign last_chunk = (rem_ff == xfer_ff);
   assign accept     = req_valid && req_ready;

   // Sequence control
   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      writing_in  = writing_ff;
      awaiting_in = awaiting_ff;
      pos_in      = pos_ff;
      rem_in      = rem_ff;
      done_in     = done_ff;
      sectors_in  = sectors_ff;
      xfer_in     = xfer_ff;
      partial_in  = partial_ff;
      req_ready   = 1'b0;
      push        = '0;
      case (state_ff)
         ST_READY: begin
            req_ready = q_room;
            if (accept) begin
               if (req_kind == KIND_REQUEST) begin
                  // Start a transfer; drop it when one is running
                  if (!active_ff) begin
                     writing_in  = req_write_request;
                     pos_in      = req_start_offset;
                     rem_in      = req_request_bytes;
                     done_in     = '0;
                     awaiting_in = AW_NONE;
                     if (req_request_bytes == '0) begin
                        push.num  = 2'd1;
                        push.rec0 = make_rsp(RK_DONE, '0, '0, '0, '0, '0, 1'b1);
                     end else begin
                        active_in = 1'b1;
                        state_in  = ST_SPAN;
                     end
                  end
               end else if (active_ff && awaiting_ff != AW_NONE) begin
                  if (req_command_failed) begin
                     // Report what was moved, or the error
                     active_in   = 1'b0;
                     awaiting_in = AW_NONE;
                     push.num    = 2'd1;
                     if (done_ff != '0) begin
                        push.rec0 = make_rsp(RK_DONE, '0, '0, '0, '0, done_ff, 1'b1);
                     end else begin
                        push.rec0 = make_rsp(RK_FAIL, '0, '0, '0, '0, '0, 1'b1);
                     end
                  end else begin
                     case (awaiting_ff)
                        AW_DATA_READ: begin
                           push.rec0 = make_rsp(RK_TO_BUFFER, '0, '0, soff_out,
                                                done_ff, xfer_ff, 1'b0);
                           if (last_chunk) begin
                              push.num    = 2'd2;
                              push.rec1   = make_rsp(RK_DONE, '0, '0, '0, '0,
                                                     done_sum, 1'b1);
                              active_in   = 1'b0;
                              awaiting_in = AW_NONE;
                           end else begin
                              push.num    = 2'd1;
                              done_in     = done_sum;
                              pos_in      = pos_ff + POS_W'(xfer_ff);
                              rem_in      = rem_ff - xfer_ff;
                              awaiting_in = AW_NONE;
                              state_in    = ST_SPAN;
                           end
                        end
                        AW_MERGE_READ: begin
                           push.num    = 2'd2;
                           push.rec0   = make_rsp(RK_TO_SCRATCH, '0, '0, soff_out,
                                                  done_ff, xfer_ff, 1'b0);
                           push.rec1   = make_rsp(RK_WRITE, lba, cnt_out, '0, '0,
                                                  '0, 1'b1);
                           awaiting_in = AW_WRITE;
                        end
                        AW_WRITE: begin
                           awaiting_in = AW_NONE;
                           if (last_chunk) begin
                              push.num  = 2'd1;
                              push.rec0 = make_rsp(RK_DONE, '0, '0, '0, '0,
                                                   done_sum, 1'b1);
                              active_in = 1'b0;
                           end else begin
                              done_in  = done_sum;
                              pos_in   = pos_ff + POS_W'(xfer_ff);
                              rem_in   = rem_ff - xfer_ff;
                              state_in = ST_SPAN;
                           end
                        end
                        default: begin
                           awaiting_in = AW_NONE;
                        end
                     endcase
                  end
               end
            end
         end
         ST_SPAN: begin
            sectors_in = sec_cap;
            state_in   = ST_CHUNK;
         end
         ST_CHUNK: begin
            xfer_in    = xfer_calc;
            partial_in = partial_calc;
            state_in   = ST_ISSUE;
         end
         ST_ISSUE: begin
            // Issue the chunk's first command once the queue has room
            if (q_room) begin
               state_in = ST_READY;
               if (writing_ff && !partial_ff) begin
                  push.num    = 2'd2;
                  push.rec0   = make_rsp(RK_TO_SCRATCH, '0, '0, soff_out, done_ff,
                                         xfer_ff, 1'b0);
                  push.rec1   = make_rsp(RK_WRITE, lba, cnt_out, '0, '0, '0, 1'b1);
                  awaiting_in = AW_WRITE;
               end else begin
                  push.num    = 2'd1;
                  push.rec0   = make_rsp(RK_READ, lba, cnt_out, '0, '0, '0, 1'b1);
                  awaiting_in = writing_ff ? AW_MERGE_READ : AW_DATA_READ;
               end
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_READY;
         active_ff   <= 1'b0;
         writing_ff  <= 1'b0;
         awaiting_ff <= AW_NONE;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         writing_ff  <= writing_in;
         awaiting_ff <= awaiting_in;
      end
   end

   // Transfer position and chunk values
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      rem_ff     <= rem_in;
      done_ff    <= done_in;
      sectors_ff <= sectors_in;
      xfer_ff    <= xfer_in;
      partial_ff <= partial_in;
   end

endmodule

`default_nettype wire

### hw/rtl/srmw_queue.sv
// Result queue between front and back: two writes and one read per cycle.
// Depends on srmw_pkg for the result record and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module srmw_queue import srmw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  srmw_push_type push,
   input  logic          pop,
   output srmw_rsp_type  head,
   output logic          q_valid,
   output logic          q_room
);

   srmw_rsp_type    entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] cnt_ff, cnt_in;
   logic [Q_AW-1:0] wr_ptr_nx;

   assign wr_ptr_nx = wr_ptr_ff + Q_AW'(1);
   assign head      = entry_ff[rd_ptr_ff];
   assign q_valid   = (cnt_ff != '0);
   assign q_room    = (cnt_ff <= Q_CW'(Q_DEPTH - 2));

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_AW'(push.num);
      rd_ptr_in = rd_ptr_ff + Q_AW'(pop);
      cnt_in    = cnt_ff + Q_CW'(push.num) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store pushed records in order
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push.rec1;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/srmw_back.sv
// Back part: moves queued results into the output register toward the receiver.
// Depends on srmw_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module srmw_back import srmw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  srmw_rsp_type head,
   input  logic         q_valid,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output srmw_rsp_type rsp
);

   logic         valid_ff, valid_in;
   srmw_rsp_type rsp_ff;

   // Refill when the register is empty or its item is taken
   assign pop       = q_valid && (!valid_ff || rsp_ready);
   assign valid_in  = pop || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= head;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/sector_rmw_transfer_splitter_top.sv
// Top level of the sector read-modify-write transfer splitter.
// Depends on srmw_pkg, srmw_front, srmw_queue and srmw_back.
//
// Usage:
//   The req_ channel carries transfer requests (req_kind 0) and drive command
//   completions (req_kind 1). The rsp_ channel returns the commands, scratch
//   copies and final status for each item; rsp_last_result marks the last
//   result an item causes (zero, one or two results per item).
//   Both channels use valid/ready; an item moves when both are high.
//   An item that is ignored, ends the transfer, fails or follows a merge
//   read is handled as it is accepted. An item that opens a new chunk is
//   accepted, then passes through the chunk arithmetic (sector span, then
//   bytes moved) and issues the first command once the queue has room; no
//   item is taken meanwhile. Results leave one per cycle while the receiver
//   is ready, passing through a four-entry queue and the output register.
//   When the receiver stalls, the queue fills; req_ready drops once fewer
//   than two entries are free, and resumes as results drain.
//   Synchronous reset returns the block to idle with nothing outstanding and
//   empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module sector_rmw_transfer_splitter_top import srmw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [POS_W-1:0]  req_start_offset,
   input  logic [SIZE_W-1:0] req_request_bytes,
   input  logic              req_write_request,
   input  logic              req_command_failed,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_result_kind,
   output logic [LBA_W-1:0]  rsp_lba,
   output logic [CNT_W-1:0]  rsp_sector_count,
   output logic [SOFF_W-1:0] rsp_scratch_offset,
   output logic [SIZE_W-1:0] rsp_buffer_offset,
   output logic [SIZE_W-1:0] rsp_byte_length,
   output logic              rsp_last_result
);

   srmw_push_type push;
   srmw_rsp_type  head;
   srmw_rsp_type  rsp;
   logic          q_valid;
   logic          q_room;
   logic          pop;

   srmw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_start_offset   (req_start_offset),
      .req_request_bytes  (req_request_bytes),
      .req_write_request  (req_write_request),
      .req_command_failed (req_command_failed),
      .q_room             (q_room),
      .push               (push)
   );

   srmw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .head    (head),
      .q_valid (q_valid),
      .q_room  (q_room)
   );

   srmw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_valid   (q_valid),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Unpack the result record onto the ports
   assign rsp_result_kind    = rsp.kind;
   assign rsp_lba            = rsp.lba;
   assign rsp_sector_count   = rsp.num_sectors;
   assign rsp_scratch_offset = rsp.scratch_offset;
   assign rsp_buffer_offset  = rsp.buffer_offset;
   assign rsp_byte_length    = rsp.byte_length;
   assign rsp_last_result    = rsp.last;

   // Front pushes only when the queue can take two records
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> q_room)
      else $error("result pushed without queue room");

   // A double push ends the item's results on its second record only
   a_push_last: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> push.rec1.last && !push.rec0.last)
      else $error("last flag misplaced in double push");

   // Reset leaves no result queued or presented
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !q_valid)
      else $error("result pending after reset");

endmodule

`default_nettype wire

### test/srmw_result_checker.sv
// Result checker for the sector read-modify-write transfer splitter.
// Tracks the transfer from accepted items, predicts each command and copy, and compares
// them with the rsp_ channel. Depends on srmw_pkg.
`timescale 1ns / 1ps

module srmw_result_checker import srmw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic [POS_W-1:0]  req_start_offset,
   input  logic [SIZE_W-1:0] req_request_bytes,
   input  logic              req_write_request,
   input  logic              req_command_failed,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [2:0]        rsp_result_kind,
   input  logic [LBA_W-1:0]  rsp_lba,
   input  logic [CNT_W-1:0]  rsp_sector_count,
   input  logic [SOFF_W-1:0] rsp_scratch_offset,
   input  logic [SIZE_W-1:0] rsp_buffer_offset,
   input  logic [SIZE_W-1:0] rsp_byte_length,
   input  logic              rsp_last_result,
   output int                items_taken,
   output int                results_pending,
   output logic              transfer_open,
   output int                mismatches
);

   // Transfer state as the block should hold it
   logic              xfer_active;
   logic              xfer_write;
   srmw_await_type    cmd_wait;
   logic [POS_W-1:0]  base_offset;
   logic [SIZE_W-1:0] total_bytes;
   logic [SIZE_W-1:0] moved_bytes;

   // Geometry of the chunk at the current position
   longint unsigned   ck_lba;
   longint unsigned   ck_soff;
   longint unsigned   ck_sectors;
   longint unsigned   ck_xfer;
   logic              ck_partial;

   // Commands and copies still to come, oldest first
   srmw_rsp_type      expected_cmds[$];
   srmw_rsp_type      item_cmds[0:1];
   int                item_cmd_count;
   srmw_rsp_type      oldest;

   // Work out LBA, sector offset, sector count and bytes moved for the next chunk
   function automatic void chunk_geometry();
      logic [POS_W-1:0] pos;
      longint unsigned  remaining;
      longint unsigned  span;
      longint unsigned  whole;
      longint unsigned  room;
      pos        = base_offset + POS_W'(moved_bytes);
      ck_lba     = 64'(pos) / 64'(SECTOR_BYTES);
      ck_soff    = 64'(pos) % 64'(SECTOR_BYTES);
      remaining  = 64'(total_bytes) - 64'(moved_bytes);
      span       = ck_soff + remaining;
      ck_sectors = (span + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
      if (ck_sectors > 64'(BOUNCE_SECTORS))
         ck_sectors = 64'(BOUNCE_SECTORS);
      whole      = ck_sectors * 64'(SECTOR_BYTES);
      room       = whole - ck_soff;
      ck_xfer    = (remaining < room) ? remaining : room;
      ck_partial = (ck_soff != 64'd0) || (ck_xfer != whole);
   endfunction

   function automatic void add_cmd(input srmw_kind_type kind, input longint unsigned lba,
         input longint unsigned count, input longint unsigned soff,
         input longint unsigned boff, input longint unsigned len);
      srmw_rsp_type r;
      r.kind           = kind;
      r.lba            = LBA_W'(lba);
      r.num_sectors    = CNT_W'(count);
      r.scratch_offset = SOFF_W'(soff);
      r.buffer_offset  = SIZE_W'(boff);
      r.byte_length    = SIZE_W'(len);
      r.last           = 1'b0;
      item_cmds[item_cmd_count] = r;
      item_cmd_count++;
   endfunction

   // Issue the first step of the next chunk: merge read, direct write or data read
   function automatic void open_chunk();
      chunk_geometry();
      if (xfer_write && ck_partial) begin
         add_cmd(RK_READ, ck_lba, ck_sectors, 0, 0, 0);
         cmd_wait = AW_MERGE_READ;
      end else if (xfer_write) begin
         add_cmd(RK_TO_SCRATCH, 0, 0, ck_soff, 64'(moved_bytes), ck_xfer);
         add_cmd(RK_WRITE, ck_lba, ck_sectors, 0, 0, 0);
         cmd_wait = AW_WRITE;
      end else begin
         add_cmd(RK_READ, ck_lba, ck_sectors, 0, 0, 0);
         cmd_wait = AW_DATA_READ;
      end
   endfunction

   function automatic void close_transfer();
      add_cmd(RK_DONE, 0, 0, 0, 0, 64'(moved_bytes));
      xfer_active = 1'b0;
      cmd_wait    = AW_NONE;
   endfunction

   function automatic void advance_chunk(input longint unsigned xfer);
      moved_bytes = moved_bytes + SIZE_W'(xfer);
      if (moved_bytes >= total_bytes)
         close_transfer();
      else
         open_chunk();
   endfunction

   // Apply one accepted item and queue the results it causes
   function automatic void predict_item(input logic kind, input logic [POS_W-1:0] offset,
         input logic [SIZE_W-1:0] bytes, input logic write, input logic failed);
      item_cmd_count = 0;
      if (kind == KIND_REQUEST) begin
         if (!xfer_active) begin
            xfer_active = 1'b1;
            base_offset = offset;
            total_bytes = bytes;
            xfer_write  = write;
            moved_bytes = '0;
            cmd_wait    = AW_NONE;
            if (total_bytes == '0)
               close_transfer();
            else
               open_chunk();
         end
      end else if (xfer_active && cmd_wait != AW_NONE) begin
         if (failed && moved_bytes != '0) begin
            close_transfer();
         end else if (failed) begin
            add_cmd(RK_FAIL, 0, 0, 0, 0, 0);
            xfer_active = 1'b0;
            cmd_wait    = AW_NONE;
         end else begin
            chunk_geometry();
            case (cmd_wait)
               AW_DATA_READ: begin
                  add_cmd(RK_TO_BUFFER, 0, 0, ck_soff, 64'(moved_bytes), ck_xfer);
                  advance_chunk(ck_xfer);
               end
               AW_MERGE_READ: begin
                  add_cmd(RK_TO_SCRATCH, 0, 0, ck_soff, 64'(moved_bytes), ck_xfer);
                  add_cmd(RK_WRITE, ck_lba, ck_sectors, 0, 0, 0);
                  cmd_wait = AW_WRITE;
               end
               default: advance_chunk(ck_xfer);
            endcase
         end
      end
      // Mark the last result of the item, then queue them in order
      if (item_cmd_count > 0)
         item_cmds[item_cmd_count - 1].last = 1'b1;
      for (int i = 0; i < item_cmd_count; i++)
         expected_cmds.push_back(item_cmds[i]);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
         input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // Compare results and track accepted items at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         xfer_active     = 1'b0;
         xfer_write      = 1'b0;
         cmd_wait        = AW_NONE;
         base_offset     = '0;
         total_bytes     = '0;
         moved_bytes     = '0;
         expected_cmds.delete();
         results_pending = 0;
         transfer_open   = 1'b0;
         items_taken     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               $error("rsp_result_kind: expected nothing, actual 0x%0h", rsp_result_kind);
               mismatches++;
            end else begin
               oldest = expected_cmds.pop_front();
               check_field("rsp_result_kind", 64'(oldest.kind), 64'(rsp_result_kind));
               check_field("rsp_lba", 64'(oldest.lba), 64'(rsp_lba));
               check_field("rsp_sector_count", 64'(oldest.num_sectors),
                           64'(rsp_sector_count));
               check_field("rsp_scratch_offset", 64'(oldest.scratch_offset),
                           64'(rsp_scratch_offset));
               check_field("rsp_buffer_offset", 64'(oldest.buffer_offset),
                           64'(rsp_buffer_offset));
               check_field("rsp_byte_length", 64'(oldest.byte_length),
                           64'(rsp_byte_length));
               check_field("rsp_last_result", 64'(oldest.last), 64'(rsp_last_result));
            end
         end
         if (req_valid && req_ready)
            predict_item(req_kind, req_start_offset, req_request_bytes, req_write_request,
                         req_command_failed);
         results_pending = expected_cmds.size();
         transfer_open   = xfer_active;
         if (req_valid && req_ready)
            items_taken++;
      end
   end

endmodule

### test/tb_sector_rmw_transfer_splitter_top.sv
// Testbench top for the sector read-modify-write transfer splitter.
// Drives requests and drive completions, stalls both channels, and gives the verdict;
// depends on srmw_pkg, srmw_result_checker and the block itself.
`timescale 1ns / 1ps

module tb_sector_rmw_transfer_splitter_top;
   import srmw_pkg::*;

   localparam int ITEM_TARGET = 550;
   localparam int QUIET_FROM  = 490;
   localparam int DRAIN_EVERY = 150;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 16;
   localparam int NO_FAILURE  = 1 << 30;

   logic              clock              = 1'b0;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_kind           = 1'b0;
   logic [POS_W-1:0]  req_start_offset   = '0;
   logic [SIZE_W-1:0] req_request_bytes  = '0;
   logic              req_write_request  = 1'b0;
   logic              req_command_failed = 1'b0;
   logic              rsp_ready          = 1'b0;

   logic              req_ready;
   logic              rsp_valid;
   logic [2:0]        rsp_result_kind;
   logic [LBA_W-1:0]  rsp_lba;
   logic [CNT_W-1:0]  rsp_sector_count;
   logic [SOFF_W-1:0] rsp_scratch_offset;
   logic [SIZE_W-1:0] rsp_buffer_offset;
   logic [SIZE_W-1:0] rsp_byte_length;
   logic              rsp_last_result;

   int                items_taken;
   int                results_pending;
   logic              transfer_open;
   int                mismatches;

   int                sent_total      = 0;
   int                effective_items = 0;
   logic              quiet           = 1'b0;
   int                ready_hold      = 0;
   int                idle_cycles     = 0;

   always #5 clock = ~clock;

   sector_rmw_transfer_splitter_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_start_offset   (req_start_offset),
      .req_request_bytes  (req_request_bytes),
      .req_write_request  (req_write_request),
      .req_command_failed (req_command_failed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_lba            (rsp_lba),
      .rsp_sector_count   (rsp_sector_count),
      .rsp_scratch_offset (rsp_scratch_offset),
      .rsp_buffer_offset  (rsp_buffer_offset),
      .rsp_byte_length    (rsp_byte_length),
      .rsp_last_result    (rsp_last_result)
   );

   srmw_result_checker result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_start_offset   (req_start_offset),
      .req_request_bytes  (req_request_bytes),
      .req_write_request  (req_write_request),
      .req_command_failed (req_command_failed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_lba            (rsp_lba),
      .rsp_sector_count   (rsp_sector_count),
      .rsp_scratch_offset (rsp_scratch_offset),
      .rsp_buffer_offset  (rsp_buffer_offset),
      .rsp_byte_length    (rsp_byte_length),
      .rsp_last_result    (rsp_last_result),
      .items_taken        (items_taken),
      .results_pending    (results_pending),
      .transfer_open      (transfer_open),
      .mismatches         (mismatches)
   );

   // Receiver: alternate random ready stretches with random stall bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 16);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 30);
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Drive one item, hold it until taken, and wait for the checker to see it
   task automatic send_item(input logic kind, input logic [POS_W-1:0] offset,
         input logic [SIZE_W-1:0] bytes, input logic write, input logic failed);
      if ((kind == KIND_REQUEST) != transfer_open)
         effective_items++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_start_offset   <= offset;
      req_request_bytes  <= bytes;
      req_write_request  <= write;
      req_command_failed <= failed;
      do @(posedge clock); while (!req_ready);
      sent_total++;
      wait (items_taken == sent_total);
   endtask

   function automatic logic [POS_W-1:0] rand_offset();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return v[POS_W-1:0];
         1: return {v[POS_W-1:SECTOR_SHIFT], SECTOR_SHIFT'(0)};
         2: return {POS_W{1'b1}} - POS_W'(v[12:0]);
         default: return POS_W'(v[15:0]);
      endcase
   endfunction

   task automatic send_request(input logic [POS_W-1:0] offset, input logic [SIZE_W-1:0] bytes,
         input logic write);
      send_item(KIND_REQUEST, offset, bytes, write, 1'($urandom_range(0, 1)));
   endtask

   // Request fields ride along with random content on completions
   task automatic send_completion(input logic failed);
      send_item(KIND_COMPLETION, rand_offset(), $urandom, 1'($urandom_range(0, 1)), failed);
   endtask

   // Open a transfer and complete its commands; fail the command after fail_after successes
   task automatic run_transfer(input logic [POS_W-1:0] offset, input logic [SIZE_W-1:0] bytes,
         input logic write, input int fail_after, input bit noisy);
      int done_cmds;
      done_cmds = 0;
      send_request(offset, bytes, write);
      while (transfer_open) begin
         if (noisy && $urandom_range(0, 11) == 0) begin
            send_request(rand_offset(), $urandom, 1'($urandom_range(0, 1)));
         end else begin
            send_completion(done_cmds >= fail_after);
            done_cmds++;
         end
      end
   endtask

   // Hold off the sender until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   task automatic directed_cases();
      // Completions with nothing outstanding
      send_completion(1'b0);
      send_completion(1'b1);
      // Empty requests finish at once
      run_transfer('0, '0, 1'b0, NO_FAILURE, 1'b0);
      run_transfer('1, '0, 1'b1, NO_FAILURE, 1'b0);
      // Read inside one sector, whole-sector write, partial write with merge read
      run_transfer(57'd100, 32'd10, 1'b0, NO_FAILURE, 1'b0);
      run_transfer(POS_W'(3 * SECTOR_BYTES), 32'd1024, 1'b1, NO_FAILURE, 1'b0);
      run_transfer(57'd7, 32'd20, 1'b1, NO_FAILURE, 1'b0);
      // Transfers across the top of the byte space, last LBA included
      run_transfer({POS_W{1'b1}} - 57'd299, 32'd5000, 1'b0, NO_FAILURE, 1'b0);
      run_transfer({POS_W{1'b1}} - 57'd4095, 32'hFFFF_FFFF, 1'b1, 2, 1'b0);
      // Drop a request that arrives while a transfer is open
      send_request(57'd5000, 32'd3000, 1'b1);
      send_request(rand_offset(), $urandom, 1'b0);
      while (transfer_open)
         send_completion(1'b0);
      // Failure with nothing moved, then after one chunk moved
      run_transfer(rand_offset(), 32'd4000, 1'b0, 0, 1'b0);
      run_transfer('0, 32'hFFFF_FFFF, 1'b0, 1, 1'b0);
   endtask

   task automatic random_traffic();
      logic [SIZE_W-1:0] bytes;
      int                fail_after;
      int                next_drain;
      next_drain = effective_items + DRAIN_EVERY;
      while (effective_items < ITEM_TARGET) begin
         if (effective_items >= QUIET_FROM)
            quiet <= 1'b1;
         if (effective_items >= next_drain) begin
            drain_results();
            next_drain = next_drain + DRAIN_EVERY;
         end
         // Occasional stray completion while idle
         if ($urandom_range(0, 9) == 0)
            send_completion(1'($urandom_range(0, 1)));
         fail_after = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : NO_FAILURE;
         // Mostly small transfers; huge ones always end in a failure
         case ($urandom_range(0, 19))
            0: bytes = '0;
            1, 2: begin
               bytes      = $urandom;
               fail_after = $urandom_range(0, 3);
            end
            3, 4, 5: bytes = SIZE_W'($urandom_range(1, 16) * SECTOR_BYTES);
            6, 7: bytes = SIZE_W'($urandom_range(1, 600));
            default: bytes = SIZE_W'($urandom_range(1, 4700));
         endcase
         run_transfer(rand_offset(), bytes, 1'($urandom_range(0, 1)), fail_after, 1'b1);
      end
   endtask

   // Reset, stimulus, drain, verdict
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      directed_cases();
      drain_results();
      random_traffic();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
hw/rtl/srmw_pkg.sv
hw/rtl/srmw_front.sv
hw/rtl/srmw_queue.sv
hw/rtl/srmw_back.sv
hw/rtl/sector_rmw_transfer_splitter_top.sv
test/srmw_result_checker.sv
test/tb_sector_rmw_transfer_splitter_top.sv
